// ===== rtl/core/lcg_pkg.sv =====
package lcg_pkg;

  localparam int unsigned TableDepthDefault = 256;
  localparam int unsigned StateW = 48;
  localparam int unsigned TableW = 49;
  localparam int unsigned SampleW = 32;
  localparam int unsigned ReqW = 2;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 32;
  localparam int unsigned IdxInW = 9;

  localparam logic [StateW-1:0] LcgMul = 48'h0005_DEEC_E66D;
  localparam logic [StateW-1:0] LcgAdd = 48'h0000_0000_000B;
  localparam logic [15:0] SeedLow = 16'h330E;
  localparam logic [StateW-1:0] StateReset = 48'h1234_ABCD_330E;

  typedef enum logic [ReqW-1:0] {
    REQ_SAMPLE = 2'd0,
    REQ_TABLE  = 2'd1,
    REQ_SEED   = 2'd2,
    REQ_NONE   = 2'd3
  } req_type_e;

  typedef enum logic [1:0] {
    MODE_FAIR    = 2'd0,
    MODE_UNIFORM = 2'd1,
    MODE_TABLE   = 2'd2,
    MODE_NONE    = 2'd3
  } sample_mode_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_MODE   = 3'd0,
    CFG_FAIR   = 3'd1,
    CFG_LOW    = 3'd2,
    CFG_SPAN   = 3'd3,
    CFG_TSPAN  = 3'd4,
    CFG_OFFSET = 3'd5
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL0,
    ST_MUL1,
    ST_MUL2,
    ST_LCG,
    ST_SCALE0,
    ST_SCALE1,
    ST_SCALE2,
    ST_SEARCH_RD,
    ST_SEARCH_CMP,
    ST_FINISH,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic load_req;
    logic do_seed;
    logic do_twrite;
    logic mul_step;
    logic lcg_commit;
    logic scale_step;
    logic search_init;
    logic search_rd;
    logic search_cmp;
    logic finish;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic search_done;
    logic is_table_mode;
    logic [1:0] mul_cnt;
  } sts_t;

endpackage

// ===== rtl/core/lcg_if.sv =====
interface lcg_req_if;
  logic valid;
  logic ready;
  logic [1:0] req_type;
  logic [8:0] table_index;
  logic [48:0] table_value;
  logic [31:0] seed_value;
  modport source(output valid, req_type, table_index, table_value, seed_value, input ready);
  modport sink(input valid, req_type, table_index, table_value, seed_value, output ready);
endinterface

interface lcg_res_if;
  logic valid;
  logic ready;
  logic signed [31:0] sample_value;
  logic [47:0] raw_draw;
  modport source(output valid, sample_value, raw_draw, input ready);
  modport sink(input valid, sample_value, raw_draw, output ready);
endinterface

interface lcg_cfg_if;
  logic valid;
  logic ready;
  logic [2:0] index;
  logic [31:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

// ===== rtl/core/lcg_ctrl.sv =====
module lcg_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic [1:0]       in_req_i,
  input  logic [1:0]       mode_i,
  input  logic             out_busy_i,
  input  lcg_pkg::sts_t    sts_i,
  output logic             in_ready_o,
  output lcg_pkg::cmd_t    cmd_o
);

  lcg_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lcg_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      lcg_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_req = 1'b1;
          unique case (lcg_pkg::req_type_e'(in_req_i))
            lcg_pkg::REQ_SAMPLE: state_d = lcg_pkg::ST_MUL0;
            lcg_pkg::REQ_TABLE: cmd_o.do_twrite = 1'b1;
            lcg_pkg::REQ_SEED: cmd_o.do_seed = 1'b1;
            default: ;
          endcase
        end
      end
      lcg_pkg::ST_MUL0, lcg_pkg::ST_MUL1, lcg_pkg::ST_MUL2: begin
        cmd_o.mul_step = 1'b1;
        unique case (state_q)
          lcg_pkg::ST_MUL0: state_d = lcg_pkg::ST_MUL1;
          lcg_pkg::ST_MUL1: state_d = lcg_pkg::ST_MUL2;
          default: state_d = lcg_pkg::ST_LCG;
        endcase
      end
      lcg_pkg::ST_LCG: begin
        cmd_o.lcg_commit = 1'b1;
        state_d = lcg_pkg::ST_SCALE0;
      end
      lcg_pkg::ST_SCALE0: begin
        cmd_o.scale_step = 1'b1;
        state_d = lcg_pkg::ST_SCALE1;
      end
      lcg_pkg::ST_SCALE1: begin
        cmd_o.scale_step = 1'b1;
        state_d = lcg_pkg::ST_SCALE2;
      end
      lcg_pkg::ST_SCALE2: begin
        cmd_o.search_init = 1'b1;
        state_d = sts_i.is_table_mode ? lcg_pkg::ST_SEARCH_RD : lcg_pkg::ST_FINISH;
      end
      lcg_pkg::ST_SEARCH_RD: begin
        if (sts_i.search_done) begin
          state_d = lcg_pkg::ST_FINISH;
        end else begin
          cmd_o.search_rd = 1'b1;
          state_d = lcg_pkg::ST_SEARCH_CMP;
        end
      end
      lcg_pkg::ST_SEARCH_CMP: begin
        cmd_o.search_cmp = 1'b1;
        state_d = lcg_pkg::ST_SEARCH_RD;
      end
      lcg_pkg::ST_FINISH: begin
        cmd_o.finish = 1'b1;
        state_d = lcg_pkg::ST_OUT;
      end
      lcg_pkg::ST_OUT: begin
        if (!out_busy_i) begin
          cmd_o.out_load = 1'b1;
          state_d = lcg_pkg::ST_IDLE;
        end
      end
      default: state_d = lcg_pkg::ST_IDLE;
    endcase
  end

  logic unused_mode;
  assign unused_mode = ^mode_i;

endmodule

// ===== rtl/core/lcg_dp.sv =====
module lcg_dp #(
  parameter int unsigned TableDepth = lcg_pkg::TableDepthDefault
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  lcg_pkg::cmd_t         cmd_i,
  output lcg_pkg::sts_t         sts_o,
  input  logic [1:0]            in_req_i,
  input  logic [8:0]            in_tindex_i,
  input  logic [48:0]           in_tvalue_i,
  input  logic [31:0]           in_seed_i,
  input  logic                  cfg_we_i,
  input  logic [2:0]            cfg_idx_i,
  input  logic [31:0]           cfg_data_i,
  input  logic                  out_ready_i,
  output logic                  out_valid_o,
  output logic signed [31:0]    out_sample_o,
  output logic [47:0]           out_raw_o,
  output logic [1:0]            mode_o
);

  localparam int unsigned IdxW = $clog2(TableDepth + 1);
  localparam int unsigned MemW = (IdxW > 9) ? IdxW : 9;

  logic [1:0]          mode_q;
  logic [15:0]         fair_q;
  logic signed [31:0]  low_q, span_q;
  logic [IdxW-1:0]     tspan_q;
  logic signed [16:0]  toff_q;
  logic [47:0]         state_q, acc_q;
  logic [1:0]          mcnt_q;
  logic [IdxW-1:0]     lo_q, hi_q;
  logic [48:0]         rd_q;
  logic [48:0]         mem [TableDepth+1];
  logic [63:0]         prod_q;
  logic [1:0]          scnt_q;
  logic signed [33:0]  res_q;
  logic                neg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= 2'd0;
      fair_q  <= 16'd1;
      low_q   <= '0;
      span_q  <= 32'sd65536;
      tspan_q <= IdxW'(1);
      toff_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (lcg_pkg::cfg_idx_e'(cfg_idx_i))
        lcg_pkg::CFG_MODE: mode_q <= cfg_data_i[1:0];
        lcg_pkg::CFG_FAIR: fair_q <= cfg_data_i[15:0];
        lcg_pkg::CFG_LOW: low_q <= cfg_data_i;
        lcg_pkg::CFG_SPAN: span_q <= cfg_data_i;
        lcg_pkg::CFG_TSPAN: begin
          if (32'(cfg_data_i[8:0]) > 32'(TableDepth)) begin
            tspan_q <= IdxW'(TableDepth);
          end else begin
            tspan_q <= IdxW'(cfg_data_i[8:0]);
          end
        end
        lcg_pkg::CFG_OFFSET: toff_q <= cfg_data_i[16:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.do_twrite && (32'(in_tindex_i) <= 32'(TableDepth))) begin
      mem[IdxW'(in_tindex_i)] <= in_tvalue_i;
    end
    if (cmd_i.search_rd) begin
      rd_q <= mem[IdxW'((MemW+1)'(lo_q) + (MemW+1)'(hi_q) >> 1)];
    end
  end

  // The 48-bit product is formed from three 16-bit slices of the state.
  logic [47:0] part;
  logic [15:0] slice;
  always_comb begin
    unique case (mcnt_q)
      2'd0: slice = state_q[15:0];
      2'd1: slice = state_q[31:16];
      default: slice = state_q[47:32];
    endcase
    part = 48'(lcg_pkg::LcgMul * {32'd0, slice}) << (6'(mcnt_q) * 6'd16);
  end

  logic [47:0] xv;
  assign xv = state_q;
  logic [31:0] mag;
  assign mag = span_q[31] ? 32'(-span_q) : 32'(span_q);
  logic [23:0] xsl;
  assign xsl = (scnt_q == 2'd0) ? xv[23:0] : xv[47:24];
  logic [63:0] sprod;
  assign sprod = 64'(mag) * 64'(xsl);

  logic [IdxW-1:0] mid;
  assign mid = IdxW'(((MemW+1)'(lo_q) + (MemW+1)'(hi_q)) >> 1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lcg_pkg::StateReset;
      out_valid_o <= 1'b0;
    end else begin
      if (cmd_i.do_seed) begin
        state_q <= {in_seed_i, lcg_pkg::SeedLow};
      end else if (cmd_i.lcg_commit) begin
        state_q <= acc_q;
      end
      if (cmd_i.out_load) begin
        out_valid_o <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_o <= 1'b0;
      end
    end
  end

  logic unused_req;
  assign unused_req = ^in_req_i;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_req) begin
      acc_q <= lcg_pkg::LcgAdd;
      mcnt_q <= 2'd0;
      scnt_q <= 2'd0;
    end
    if (cmd_i.mul_step) begin
      acc_q <= acc_q + part;
      mcnt_q <= mcnt_q + 2'd1;
    end
    if (cmd_i.scale_step) begin
      scnt_q <= scnt_q + 2'd1;
      if (scnt_q == 2'd0) begin
        prod_q <= sprod;
      end else begin
        // mid = ph + (pl >> 24); remainder tracked in neg_q.
        prod_q <= sprod + (prod_q >> 24);
        neg_q <= span_q[31] && ((prod_q[23:0] != 24'd0) ||
                 ((sprod + (prod_q >> 24)) & 64'hFF_FFFF) != 64'd0);
      end
    end
    if (cmd_i.search_init) begin
      lo_q <= '0;
      hi_q <= tspan_q;
    end
    if (cmd_i.search_cmp) begin
      if ({1'b0, xv} < rd_q) begin
        hi_q <= mid;
      end else begin
        lo_q <= mid + IdxW'(1);
      end
    end
    if (cmd_i.finish) begin
      unique case (lcg_pkg::sample_mode_e'(mode_q))
        lcg_pkg::MODE_FAIR: res_q <= 34'(64'(fair_q) * 64'(xv) >> 48);
        lcg_pkg::MODE_UNIFORM: begin
          if (span_q[31]) begin
            res_q <= 34'(low_q) - 34'(prod_q[63:24]) - (neg_q ? 34'sd1 : 34'sd0);
          end else begin
            res_q <= 34'(low_q) + 34'(prod_q[63:24]);
          end
        end
        lcg_pkg::MODE_TABLE: res_q <= 34'(toff_q) + 34'(hi_q);
        default: res_q <= '0;
      endcase
    end
    if (cmd_i.out_load) begin
      out_raw_o <= xv;
      if (res_q > 34'sd2147483647) begin
        out_sample_o <= 32'sh7FFF_FFFF;
      end else if (res_q < -34'sd2147483648) begin
        out_sample_o <= 32'sh8000_0000;
      end else begin
        out_sample_o <= res_q[31:0];
      end
    end
  end

  assign sts_o.search_done = (lo_q >= hi_q);
  assign sts_o.is_table_mode = (mode_q == lcg_pkg::MODE_TABLE);
  assign sts_o.mul_cnt = mcnt_q;
  assign mode_o = mode_q;

endmodule

// ===== rtl/core/lcg_inverse_cdf_sampler_core.sv =====
// Random sampler on a 48-bit drand48 generator. Each input item is a sample draw,
// a table write, a reseed or a no-op; only a draw gives a result item. A new item
// is taken only once the previous one is through. A draw in fair and uniform mode
// runs three 16-bit multiply-add steps, a state commit, two 24-bit scaling steps,
// the mode select, the final sum and the output load. In table mode a binary
// search over the table comes between the mode select and the final sum, each
// search step a table memory read and a compare, up to nine search steps for a
// 256-entry span. A result item that waits on the output holds the next draw in
// its last cycle. The table is not cleared by reset.
module lcg_inverse_cdf_sampler_core #(
  parameter int unsigned TableDepth = lcg_pkg::TableDepthDefault
) (
  input logic clk_i,
  input logic rst_ni,
  lcg_req_if.sink   req,
  lcg_res_if.source res,
  lcg_cfg_if.sink   cfg
);

  lcg_pkg::cmd_t cmd;
  lcg_pkg::sts_t sts;
  logic [1:0] mode;

  assign cfg.ready = 1'b1;

  lcg_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(req.valid), .in_req_i(req.req_type), .mode_i(mode),
    .out_busy_i(res.valid && !res.ready), .sts_i(sts),
    .in_ready_o(req.ready), .cmd_o(cmd)
  );

  lcg_dp #(.TableDepth(TableDepth)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts),
    .in_req_i(req.req_type), .in_tindex_i(req.table_index),
    .in_tvalue_i(req.table_value), .in_seed_i(req.seed_value),
    .cfg_we_i(cfg.valid), .cfg_idx_i(cfg.index), .cfg_data_i(cfg.data),
    .out_ready_i(res.ready), .out_valid_o(res.valid),
    .out_sample_o(res.sample_value), .out_raw_o(res.raw_draw), .mode_o(mode)
  );

endmodule

// ===== rtl/core/lcg_checker.sv =====
module lcg_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic [47:0] raw
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(raw)) else $error("result dropped");
  a_noacc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(out_valid) |-> $past(out_ready)) else $error("result withdrawn");
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid) |-> in_ready) else $error("not ready after draw");
  a_rst: assert property (@(posedge clk_i) !rst_ni |=> !out_valid || rst_ni)
    else $error("valid out of reset");

endmodule

bind lcg_inverse_cdf_sampler_core lcg_checker u_chk (
  .clk_i, .rst_ni, .in_valid(req.valid), .in_ready(req.ready),
  .out_valid(res.valid), .out_ready(res.ready), .raw(res.raw_draw)
);
